[rtl/abdf_pkg.sv]
package abdf_pkg;

   localparam int unsigned HistoryBits = 8;
   localparam logic [7:0] HistMask = 8'((1 << HistoryBits) - 1);

   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] OneQ32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] TolK = 64'd4611686018;
   localparam logic [63:0] HalfQ32 = 64'h0000_0000_8000_0000;
   localparam logic [63:0] TwoQ32 = 64'h0000_0002_0000_0000;
   localparam logic [63:0] TrialScale = 64'd10000;
   localparam logic [63:0] MinScale = 64'd10001;
   localparam logic [63:0] SqrtTopBit = 64'h4000_0000_0000_0000;

   localparam logic [1:0] CmdSelect = 2'd0;
   localparam logic [1:0] CmdElement = 2'd1;
   localparam logic [1:0] CmdBoundary = 2'd2;

   localparam logic [1:0] KindChoice = 2'd0;
   localparam logic [1:0] KindVerdict = 2'd1;
   localparam logic [1:0] KindBoundary = 2'd2;

   localparam logic [2:0] RegInitialStep = 3'd0;
   localparam logic [2:0] RegMinStep = 3'd1;
   localparam logic [2:0] RegMaxStep = 3'd2;
   localparam logic [2:0] RegOutputInterval = 3'd3;
   localparam logic [2:0] RegSafetyFactor = 3'd4;
   localparam logic [2:0] RegErrorTolerance = 3'd5;
   localparam logic [2:0] RegHighestOrder = 3'd6;

   localparam logic [1:0] OpMul = 2'd0;
   localparam logic [1:0] OpDiv = 2'd1;
   localparam logic [1:0] OpSqrt = 2'd2;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
   } arith_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] result;
   } arith_rsp_type;

endpackage

[rtl/abdf_ifs.sv]
interface abdf_req_if import abdf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] time_now;
   logic [63:0] run_length;
   logic [7:0]  history_count;
   logic [63:0] temp_trial;
   logic [63:0] temp_prev;
   logic [63:0] temp_prev_two;
   logic [63:0] trial_step;
   logic [63:0] previous_step;
   logic        final_element;
   logic        empty_vector;
   modport source (output valid, cmd, time_now, run_length, history_count, temp_trial,
                   temp_prev, temp_prev_two, trial_step, previous_step, final_element,
                   empty_vector, input ready);
   modport sink (input valid, cmd, time_now, run_length, history_count, temp_trial,
                 temp_prev, temp_prev_two, trial_step, previous_step, final_element,
                 empty_vector, output ready);
endinterface

interface abdf_rsp_if import abdf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [63:0] chosen_step;
   logic [1:0]  chosen_order;
   logic        step_accepted;
   logic        on_boundary;
   logic [63:0] proposed_step;
   modport source (output valid, result_kind, chosen_step, chosen_order, step_accepted,
                   on_boundary, proposed_step, input ready);
   modport sink (input valid, result_kind, chosen_step, chosen_order, step_accepted,
                 on_boundary, proposed_step, output ready);
endinterface

interface abdf_csr_if import abdf_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/adaptive_bdf_step_controller.sv]
// Channel  | Dir | Interface   | Transaction
// req_chan | in  | abdf_req_if | one command or error element
// rsp_chan | out | abdf_rsp_if | step choice, verdict or boundary answer
// csr_chan | in  | abdf_csr_if | one register write, always ready
// One shared multiply/divide/sqrt unit steps one bit per cycle (64 for multiply and
// divide, 32 for sqrt). cmd 0 and 2 use up to two operations, an element up to
// three, a final element nine. req ready only while idle.
// Reset is synchronous and clears all step state. A stalled result holds in the
// output register; the next transaction is taken meanwhile.
module adaptive_bdf_step_controller import abdf_pkg::*; (
   input logic       clock,
   input logic       reset,
   abdf_req_if.sink   req_chan,
   abdf_rsp_if.source rsp_chan,
   abdf_csr_if.sink   csr_chan
);

   localparam logic [4:0] StIdle = 5'd0, StLTn = 5'd1, StWTn = 5'd2, StLTol = 5'd3,
      StWTol = 5'd4, StFin0 = 5'd5, StFin2 = 5'd6, StLRatio = 5'd7, StWRatio = 5'd8,
      StLMp = 5'd9, StWMp = 5'd10, StLRel = 5'd11, StWRel = 5'd12, StLQ = 5'd13,
      StWQ = 5'd14, StLSq = 5'd15, StWSq = 5'd16, StLFac = 5'd17, StWFac = 5'd18,
      StLCalc = 5'd19, StWCalc = 5'd20, StLA1 = 5'd21, StWA1 = 5'd22, StLA2 = 5'd23,
      StWA2 = 5'd24, StFin1 = 5'd25, StFinEmpty = 5'd26;

   logic [63:0] init_ff, min_ff, max_ff, intv_ff, tol_cfg_ff;
   logic [31:0] safety_ff;
   logic [1:0]  order_ff;

   logic [4:0]  state_ff, state_in;
   logic [63:0] prop_ff, prop_in, taken_ff, taken_in, target_ff, target_in;
   logic [31:0] outs_ff, outs_in;
   logic [63:0] maxrel_ff, maxrel_in;

   logic [1:0]  cmd_ff, cmd_in;
   logic [63:0] t_ff, t_in, run_ff, run_in, tc_ff, tc_in, tp_ff, tp_in, tp2_ff, tp2_in;
   logic [63:0] trial_ff, trial_in, prev_ff, prev_in;
   logic [7:0]  hist_ff, hist_in;
   logic        last_ff, last_in;

   logic [63:0]  tn_ff, tn_in, tol_ff, tol_in, work_ff, work_in, e_ff, e_in, err_ff, err_in;
   logic [127:0] prod_ff, prod_in;
   logic         acc_ff, acc_in;

   logic        ov_ff, ov_in;
   logic [1:0]  o_kind_ff, o_kind_in, o_order_ff, o_order_in;
   logic [63:0] o_step_ff, o_step_in, o_prop_ff, o_prop_in;
   logic        o_acc_ff, o_acc_in, o_bnd_ff, o_bnd_in;

   arith_req_type arith_req;
   arith_rsp_type arith_rsp;

   abdf_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   function automatic logic [63:0] clamp(input logic [63:0] v, input logic [63:0] lo,
                                         input logic [63:0] hi);
      logic [63:0] r;
      r = v;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
   endfunction

   logic [63:0] ua, ub, ub2, m1, m2, den, mul_sat, target_c, dt, left, gap, tn_span, calc, g;
   logic        n1, n2, out_free, hit;
   logic [1:0]  ord;
   logic [32:0] kplus;

   always_comb begin
      ua = tc_ff ^ {1'b1, 63'd0};
      ub = tp_ff ^ {1'b1, 63'd0};
      ub2 = tp2_ff ^ {1'b1, 63'd0};
      n1 = ua < ub;
      m1 = n1 ? ub - ua : ua - ub;
      n2 = ub < ub2;
      m2 = n2 ? ub2 - ub : ub - ub2;
      den = tc_ff[63] ? 64'd0 - tc_ff : tc_ff;
      if (den < OneQ32) den = OneQ32;
      mul_sat = (arith_rsp.result[127:96] != 32'd0) ? AllOnes : arith_rsp.result[95:32];
      target_c = clamp((prop_ff != 64'd0) ? prop_ff : init_ff, min_ff, max_ff);
      ord = (order_ff == 2'd0) ? 2'd1 : ((order_ff > 2'd2) ? 2'd2 : order_ff);
      kplus = {1'b0, outs_ff} + 33'd1;
      gap = tn_ff - t_ff;
      dt = target_c;
      if (intv_ff != 64'd0 && tn_ff > t_ff && gap > tol_ff && gap < dt) dt = gap;
      left = (run_ff > t_ff) ? run_ff - t_ff : 64'd0;
      if (left < dt) dt = left;
      tn_span = (t_ff >= tn_ff) ? t_ff - tn_ff : tn_ff - t_ff;
      hit = (intv_ff == 64'd0) || (tn_span <= tol_ff);
      g = (work_ff < HalfQ32) ? HalfQ32 : ((work_ff > TwoQ32) ? TwoQ32 : work_ff);
      calc = e_ff;
      if (taken_ff < target_ff && work_ff >= OneQ32 && calc < target_ff) calc = target_ff;
      out_free = !ov_ff || rsp_chan.ready;
   end

   always_comb begin
      arith_req = '0;
      unique case (state_ff)
         StLTn: begin
            arith_req.op = OpMul;
            arith_req.a = {31'd0, kplus};
            arith_req.b = intv_ff;
         end
         StLTol: begin
            arith_req.op = OpMul;
            arith_req.a = (t_ff > OneQ32) ? t_ff : OneQ32;
            arith_req.b = TolK;
         end
         StLRatio: begin
            arith_req.op = OpDiv;
            arith_req.a = {32'd0, trial_ff[63:32]};
            arith_req.b = {trial_ff[31:0], 32'd0};
            arith_req.c = prev_ff;
         end
         StLMp: begin
            arith_req.op = OpMul;
            arith_req.a = work_ff;
            arith_req.b = m2;
         end
         StLRel: begin
            arith_req.op = OpDiv;
            arith_req.a = {32'd0, (hist_ff >= 8'd2) ? e_ff[63:32] : m1[63:32]};
            arith_req.b = {(hist_ff >= 8'd2) ? e_ff[31:0] : m1[31:0], 32'd0};
            arith_req.c = den;
         end
         StLQ: begin
            arith_req.op = OpDiv;
            arith_req.a = {32'd0, tol_cfg_ff[63:32]};
            arith_req.b = {tol_cfg_ff[31:0], 32'd0};
            arith_req.c = (err_ff != 64'd0) ? err_ff : 64'd1;
         end
         StLSq: begin
            arith_req.op = OpSqrt;
            arith_req.a = work_ff;
         end
         StLFac: begin
            arith_req.op = OpMul;
            arith_req.a = {32'd0, safety_ff};
            arith_req.b = work_ff;
         end
         StLCalc: begin
            arith_req.op = OpMul;
            arith_req.a = taken_ff;
            arith_req.b = g;
         end
         StLA1: begin
            arith_req.op = OpMul;
            arith_req.a = trial_ff;
            arith_req.b = TrialScale;
         end
         StLA2: begin
            arith_req.op = OpMul;
            arith_req.a = min_ff;
            arith_req.b = MinScale;
         end
         default: arith_req = '0;
      endcase
      arith_req.start = (state_ff == StLTn) || (state_ff == StLTol) ||
         (state_ff == StLRatio) || (state_ff == StLMp) || (state_ff == StLRel) ||
         (state_ff == StLQ) || (state_ff == StLSq) || (state_ff == StLFac) ||
         (state_ff == StLCalc) || (state_ff == StLA1) || (state_ff == StLA2);
   end

   always_comb begin
      state_in = state_ff;
      prop_in = prop_ff;
      taken_in = taken_ff;
      target_in = target_ff;
      outs_in = outs_ff;
      maxrel_in = maxrel_ff;
      cmd_in = cmd_ff;
      t_in = t_ff;
      run_in = run_ff;
      tc_in = tc_ff;
      tp_in = tp_ff;
      tp2_in = tp2_ff;
      trial_in = trial_ff;
      prev_in = prev_ff;
      hist_in = hist_ff;
      last_in = last_ff;
      tn_in = tn_ff;
      tol_in = tol_ff;
      work_in = work_ff;
      e_in = e_ff;
      err_in = err_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      ov_in = ov_ff && !rsp_chan.ready;
      o_kind_in = o_kind_ff;
      o_order_in = o_order_ff;
      o_step_in = o_step_ff;
      o_prop_in = o_prop_ff;
      o_acc_in = o_acc_ff;
      o_bnd_in = o_bnd_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_chan.valid) begin
               cmd_in = req_chan.cmd;
               t_in = req_chan.time_now;
               run_in = req_chan.run_length;
               hist_in = req_chan.history_count & HistMask;
               tc_in = req_chan.temp_trial;
               tp_in = req_chan.temp_prev;
               tp2_in = req_chan.temp_prev_two;
               trial_in = req_chan.trial_step;
               prev_in = req_chan.previous_step;
               last_in = req_chan.final_element;
               work_in = OneQ32;
               unique case (req_chan.cmd)
                  CmdSelect: state_in = (intv_ff != 64'd0) ? StLTn : StFin0;
                  CmdBoundary: state_in = (intv_ff != 64'd0) ? StLTn : StFin2;
                  CmdElement: begin
                     if (req_chan.empty_vector) state_in = StFinEmpty;
                     else if ((req_chan.history_count & HistMask) < 8'd2) state_in = StLRel;
                     else if (req_chan.previous_step != 64'd0) state_in = StLRatio;
                     else state_in = StLMp;
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StLTn: state_in = StWTn;
         StWTn: begin
            if (arith_rsp.done) begin
               tn_in = (arith_rsp.result[127:64] != 64'd0) ? AllOnes : arith_rsp.result[63:0];
               state_in = StLTol;
            end
         end
         StLTol: state_in = StWTol;
         StWTol: begin
            if (arith_rsp.done) begin
               tol_in = arith_rsp.result[125:62];
               state_in = (cmd_ff == CmdSelect) ? StFin0 : StFin2;
            end
         end
         StFin0: begin
            if (out_free) begin
               target_in = target_c;
               taken_in = dt;
               ov_in = 1'b1;
               o_kind_in = KindChoice;
               o_step_in = dt;
               o_order_in = (hist_ff > {6'd0, ord}) ? ord : 2'd1;
               o_acc_in = 1'b0;
               o_bnd_in = 1'b0;
               o_prop_in = 64'd0;
               state_in = StIdle;
            end
         end
         StFin2: begin
            if (out_free) begin
               if (intv_ff != 64'd0 && hit) outs_in = outs_ff + 32'd1;
               ov_in = 1'b1;
               o_kind_in = KindBoundary;
               o_step_in = 64'd0;
               o_order_in = 2'd0;
               o_acc_in = 1'b0;
               o_bnd_in = hit;
               o_prop_in = 64'd0;
               state_in = StIdle;
            end
         end
         StLRatio: state_in = StWRatio;
         StWRatio: begin
            if (arith_rsp.done) begin
               work_in = arith_rsp.result[63:0];
               state_in = StLMp;
            end
         end
         StLMp: state_in = StWMp;
         StWMp: begin
            if (arith_rsp.done) begin
               if (n1 == n2) e_in = (m1 >= mul_sat) ? m1 - mul_sat : mul_sat - m1;
               else e_in = (m1 > AllOnes - mul_sat) ? AllOnes : m1 + mul_sat;
               state_in = StLRel;
            end
         end
         StLRel: state_in = StWRel;
         StWRel: begin
            if (arith_rsp.done) begin
               if (last_ff) begin
                  err_in = (arith_rsp.result[63:0] > maxrel_ff) ?
                     arith_rsp.result[63:0] : maxrel_ff;
                  maxrel_in = 64'd0;
                  state_in = StLQ;
               end else begin
                  if (arith_rsp.result[63:0] > maxrel_ff) maxrel_in = arith_rsp.result[63:0];
                  state_in = StIdle;
               end
            end
         end
         StLQ: state_in = StWQ;
         StWQ: begin
            if (arith_rsp.done) begin
               work_in = arith_rsp.result[63:0];
               state_in = StLSq;
            end
         end
         StLSq: state_in = StWSq;
         StWSq: begin
            if (arith_rsp.done) begin
               work_in = arith_rsp.result[63:0];
               state_in = StLFac;
            end
         end
         StLFac: state_in = StWFac;
         StWFac: begin
            if (arith_rsp.done) begin
               work_in = arith_rsp.result[63:0];
               state_in = StLCalc;
            end
         end
         StLCalc: state_in = StWCalc;
         StWCalc: begin
            if (arith_rsp.done) begin
               e_in = mul_sat;
               state_in = StLA1;
            end
         end
         StLA1: state_in = StWA1;
         StWA1: begin
            if (arith_rsp.done) begin
               prod_in = arith_rsp.result;
               state_in = StLA2;
            end
         end
         StLA2: state_in = StWA2;
         StWA2: begin
            if (arith_rsp.done) begin
               acc_in = (err_ff <= tol_cfg_ff) || (prod_ff <= arith_rsp.result);
               state_in = StFin1;
            end
         end
         StFin1: begin
            if (out_free) begin
               prop_in = clamp(calc, min_ff, max_ff);
               ov_in = 1'b1;
               o_kind_in = KindVerdict;
               o_step_in = 64'd0;
               o_order_in = 2'd0;
               o_acc_in = acc_ff;
               o_bnd_in = 1'b0;
               o_prop_in = clamp(calc, min_ff, max_ff);
               state_in = StIdle;
            end
         end
         StFinEmpty: begin
            if (out_free) begin
               maxrel_in = 64'd0;
               ov_in = 1'b1;
               o_kind_in = KindVerdict;
               o_step_in = 64'd0;
               o_order_in = 2'd0;
               o_acc_in = 1'b1;
               o_bnd_in = 1'b0;
               o_prop_in = prop_ff;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= OneQ32;
         min_ff <= 64'd1;
         max_ff <= AllOnes;
         intv_ff <= 64'd0;
         safety_ff <= 32'd65536;
         tol_cfg_ff <= 64'd4294967;
         order_ff <= 2'd2;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            RegInitialStep: init_ff <= csr_chan.data;
            RegMinStep: min_ff <= csr_chan.data;
            RegMaxStep: max_ff <= csr_chan.data;
            RegOutputInterval: intv_ff <= csr_chan.data;
            RegSafetyFactor: safety_ff <= csr_chan.data[31:0];
            RegErrorTolerance: tol_cfg_ff <= csr_chan.data;
            RegHighestOrder: order_ff <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         prop_ff <= 64'd0;
         taken_ff <= 64'd0;
         target_ff <= 64'd0;
         outs_ff <= 32'd0;
         maxrel_ff <= 64'd0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prop_ff <= prop_in;
         taken_ff <= taken_in;
         target_ff <= target_in;
         outs_ff <= outs_in;
         maxrel_ff <= maxrel_in;
         ov_ff <= ov_in;
      end
      cmd_ff <= cmd_in;
      t_ff <= t_in;
      run_ff <= run_in;
      tc_ff <= tc_in;
      tp_ff <= tp_in;
      tp2_ff <= tp2_in;
      trial_ff <= trial_in;
      prev_ff <= prev_in;
      hist_ff <= hist_in;
      last_ff <= last_in;
      tn_ff <= tn_in;
      tol_ff <= tol_in;
      work_ff <= work_in;
      e_ff <= e_in;
      err_ff <= err_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      o_kind_ff <= o_kind_in;
      o_order_ff <= o_order_in;
      o_step_ff <= o_step_in;
      o_prop_ff <= o_prop_in;
      o_acc_ff <= o_acc_in;
      o_bnd_ff <= o_bnd_in;
   end

   assign req_chan.ready = (state_ff == StIdle);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = ov_ff;
   assign rsp_chan.result_kind = o_kind_ff;
   assign rsp_chan.chosen_step = o_step_ff;
   assign rsp_chan.chosen_order = o_order_ff;
   assign rsp_chan.step_accepted = o_acc_ff;
   assign rsp_chan.on_boundary = o_bnd_ff;
   assign rsp_chan.proposed_step = o_prop_ff;

endmodule

[rtl/abdf_arith.sv]
module abdf_arith import abdf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type arith_req,
   output arith_rsp_type arith_rsp
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [1:0]   op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] w_ff, w_in;
   logic [63:0]  m_ff, m_in;

   logic [64:0]  sum65;
   logic [64:0]  rem65;
   logic         ge;
   logic [63:0]  rb;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      w_in = w_ff;
      m_in = m_ff;
      sum65 = {1'b0, w_ff[127:64]} + (w_ff[0] ? {1'b0, m_ff} : 65'd0);
      rem65 = {w_ff[127:64], w_ff[63]};
      ge = rem65 >= {1'b0, m_ff};
      rb = w_ff[63:0] + m_ff;
      if (arith_req.start) begin
         op_in = arith_req.op;
         unique case (arith_req.op)
            OpMul: begin
               w_in = {64'd0, arith_req.b};
               m_in = arith_req.a;
               cnt_in = 7'd64;
               busy_in = 1'b1;
            end
            OpDiv: begin
               if (arith_req.a >= arith_req.c) begin
                  w_in = {64'd0, AllOnes};
                  done_in = 1'b1;
               end else begin
                  w_in = {arith_req.a, arith_req.b};
                  m_in = arith_req.c;
                  cnt_in = 7'd64;
                  busy_in = 1'b1;
               end
            end
            OpSqrt: begin
               w_in = {arith_req.a, 64'd0};
               m_in = SqrtTopBit;
               cnt_in = 7'd32;
               busy_in = 1'b1;
            end
            default: done_in = 1'b1;
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OpMul: w_in = {sum65, w_ff[63:1]};
            OpDiv: begin
               if (ge) rem65 = rem65 - {1'b0, m_ff};
               w_in = {rem65[63:0], w_ff[62:0], ge};
            end
            OpSqrt: begin
               if (w_ff[127:64] >= rb) begin
                  w_in = {w_ff[127:64] - rb, (w_ff[63:0] >> 1) + m_ff};
               end else begin
                  w_in = {w_ff[127:64], w_ff[63:0] >> 1};
               end
               m_in = m_ff >> 2;
            end
            default: w_in = w_ff;
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 7'd0;
         op_ff <= OpMul;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
      end
      w_ff <= w_in;
      m_ff <= m_in;
   end

   assign arith_rsp.done = done_ff;
   assign arith_rsp.result = w_ff;

endmodule

[bench/abdf_pred_pkg.sv]
`timescale 1ns / 1ps
package abdf_pred_pkg;
   import abdf_pkg::*;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] time_now;
      logic [63:0] run_length;
      logic [7:0]  history_count;
      logic [63:0] temp_trial;
      logic [63:0] temp_prev;
      logic [63:0] temp_prev_two;
      logic [63:0] trial_step;
      logic [63:0] previous_step;
      logic        final_element;
      logic        empty_vector;
   } step_cmd_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] chosen_step;
      logic [1:0]  chosen_order;
      logic        step_accepted;
      logic        on_boundary;
      logic [63:0] proposed_step;
   } step_answer_type;
endpackage

[bench/abdf_tb_ifs.sv]
`timescale 1ns / 1ps

[bench/abdf_step_checker.sv]
`timescale 1ns / 1ps
module abdf_step_checker import abdf_pkg::*; import abdf_pred_pkg::*; (
   input  logic clock,
   input  logic reset,
   abdf_req_if.sink  req_mon,
   abdf_rsp_if.sink  rsp_mon,
   abdf_csr_if.sink  csr_mon,
   output int        error_count,
   output int        pending_count
);
   logic [63:0] r_init, r_min, r_max, r_intv, r_tol;
   logic [31:0] r_safety;
   logic [1:0]  r_order;
   logic [63:0] s_prop, s_taken, s_target, s_maxrel;
   logic [31:0] s_outs;
   step_answer_type answers_q[$];

   function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (p[127:96] != 0) ? AllOnes : p[95:32];
   endfunction

   function automatic logic [63:0] divq(logic [63:0] n, logic [63:0] d);
      logic [127:0] num, q;
      num = {32'd0, n, 32'd0};
      if (n[63:32] >= d) return AllOnes;
      q = num / {64'd0, d};
      return q[63:0];
   endfunction

   function automatic logic [63:0] sqrt64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = SqrtTopBit;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] clamp(logic [63:0] v);
      if (v > r_max) v = r_max;
      if (v < r_min) v = r_min;
      return v;
   endfunction

   function automatic logic [63:0] tol_of(logic [63:0] t);
      logic [127:0] p;
      p = {64'd0, ((t > OneQ32) ? t : OneQ32)} * {64'd0, TolK};
      return p[125:62];
   endfunction

   function automatic logic [63:0] next_mark();
      logic [127:0] p;
      p = {64'd0, ({32'd0, s_outs} + 64'd1)} * {64'd0, r_intv};
      return (p[127:64] != 0) ? AllOnes : p[63:0];
   endfunction

   function automatic logic [63:0] mag_diff(logic [63:0] a, logic [63:0] b, output logic neg);
      logic signed [64:0] d;
      d = $signed({a[63], a}) - $signed({b[63], b});
      neg = d[64];
      return neg ? 64'(-d) : d[63:0];
   endfunction

   task automatic predict_step(input step_cmd_type c);
      step_answer_type a;
      logic [63:0] dt, left, tn, m1, m2, mp, e, den, rel, q, fac, g, calc, ratio, err, d;
      logic [1:0]  ord;
      logic        n1, n2, acc, hit;
      logic [7:0]  hist;
      a = '0;
      hist = c.history_count & HistMask;
      case (c.cmd)
         CmdSelect: begin
            ord = (r_order == 0) ? 2'd1 : ((r_order > 2) ? 2'd2 : r_order);
            s_target = clamp((s_prop != 0) ? s_prop : r_init);
            dt = s_target;
            if (r_intv != 0) begin
               tn = next_mark();
               if (tn > c.time_now && tn - c.time_now > tol_of(c.time_now)
                   && tn - c.time_now < dt) dt = tn - c.time_now;
            end
            left = (c.run_length > c.time_now) ? c.run_length - c.time_now : 64'd0;
            if (left < dt) dt = left;
            s_taken = dt;
            a.result_kind = KindChoice;
            a.chosen_step = dt;
            a.chosen_order = (hist > ord) ? ord : 2'd1;
            answers_q.push_back(a);
         end
         CmdElement: begin
            if (c.empty_vector) begin
               s_maxrel = 0;
               a.result_kind = KindVerdict;
               a.step_accepted = 1'b1;
               a.proposed_step = s_prop;
               answers_q.push_back(a);
            end else begin
               m1 = mag_diff(c.temp_trial, c.temp_prev, n1);
               if (hist >= 2) begin
                  ratio = (c.previous_step != 0) ? divq(c.trial_step, c.previous_step)
                                                 : OneQ32;
                  m2 = mag_diff(c.temp_prev, c.temp_prev_two, n2);
                  mp = mulq(ratio, m2);
                  if (n1 == n2) e = (m1 >= mp) ? m1 - mp : mp - m1;
                  else e = (m1 > AllOnes - mp) ? AllOnes : m1 + mp;
               end else begin
                  e = m1;
               end
               den = c.temp_trial[63] ? -c.temp_trial : c.temp_trial;
               if (den < OneQ32) den = OneQ32;
               rel = divq(e, den);
               if (rel > s_maxrel) s_maxrel = rel;
               if (c.final_element) begin
                  err = s_maxrel;
                  s_maxrel = 0;
                  q = divq(r_tol, (err != 0) ? err : 64'd1);
                  fac = {32'd0, r_safety} * sqrt64(q);
                  g = (fac < HalfQ32) ? HalfQ32 : ((fac > TwoQ32) ? TwoQ32 : fac);
                  calc = mulq(s_taken, g);
                  if (s_taken < s_target && fac >= OneQ32 && calc < s_target)
                     calc = s_target;
                  s_prop = clamp(calc);
                  acc = (err <= r_tol) ||
                        ({64'd0, c.trial_step} * {64'd0, TrialScale} <=
                         {64'd0, r_min} * {64'd0, MinScale});
                  a.result_kind = KindVerdict;
                  a.step_accepted = acc;
                  a.proposed_step = s_prop;
                  answers_q.push_back(a);
               end
            end
         end
         CmdBoundary: begin
            hit = 1'b1;
            if (r_intv != 0) begin
               tn = next_mark();
               d = (c.time_now >= tn) ? c.time_now - tn : tn - c.time_now;
               hit = d <= tol_of(c.time_now);
               if (hit) s_outs = s_outs + 1;
            end
            a.result_kind = KindBoundary;
            a.on_boundary = hit;
            answers_q.push_back(a);
         end
         default: ;
      endcase
   endtask

   assign pending_count = answers_q.size();

   always @(posedge clock) begin
      step_cmd_type    c;
      step_answer_type got, want;
      if (reset) begin
         r_init = OneQ32; r_min = 64'd1; r_max = AllOnes; r_intv = 0;
         r_safety = 32'd65536; r_tol = 64'd4294967; r_order = 2'd2;
         s_prop = 0; s_taken = 0; s_target = 0; s_maxrel = 0; s_outs = 0;
         answers_q.delete();
         error_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               RegInitialStep:    r_init = csr_mon.data;
               RegMinStep:        r_min = csr_mon.data;
               RegMaxStep:        r_max = csr_mon.data;
               RegOutputInterval: r_intv = csr_mon.data;
               RegSafetyFactor:   r_safety = csr_mon.data[31:0];
               RegErrorTolerance: r_tol = csr_mon.data;
               RegHighestOrder:   r_order = csr_mon.data[1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.result_kind, rsp_mon.chosen_step, rsp_mon.chosen_order,
                    rsp_mon.step_accepted, rsp_mon.on_boundary, rsp_mon.proposed_step};
            if (answers_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = answers_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            c = '{req_mon.cmd, req_mon.time_now, req_mon.run_length, req_mon.history_count,
                  req_mon.temp_trial, req_mon.temp_prev, req_mon.temp_prev_two,
                  req_mon.trial_step, req_mon.previous_step, req_mon.final_element,
                  req_mon.empty_vector};
            predict_step(c);
         end
      end
   end
endmodule

[bench/adaptive_bdf_step_controller_tb.sv]
`timescale 1ns / 1ps
module adaptive_bdf_step_controller_tb import abdf_pkg::*; import abdf_pred_pkg::*; ();
   logic clock = 0;
   logic reset = 1;
   int   error_count, pending_count;
   int   cycle_count = 0;
   bit   hold_off = 0;

   abdf_req_if req_chan();
   abdf_rsp_if rsp_chan();
   abdf_csr_if csr_chan();

   adaptive_bdf_step_controller i_dut (.clock, .reset, .req_chan, .rsp_chan, .csr_chan);
   abdf_step_checker i_checker (.clock, .reset, .req_mon(req_chan), .rsp_mon(rsp_chan),
                                .csr_mon(csr_chan), .error_count, .pending_count);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 0;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_chan.ready <= 0;
            @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 16)) @(negedge clock);
            else @(negedge clock);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge64();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return AllOnes;
         2: return OneQ32;
         3: return 64'h8000_0000_0000_0000;
         4: return {32'd0, $urandom()};
         default: return rand64();
      endcase
   endfunction

   task automatic send_cmd(input step_cmd_type c);
      req_chan.valid <= 1;
      {req_chan.cmd, req_chan.time_now, req_chan.run_length, req_chan.history_count,
       req_chan.temp_trial, req_chan.temp_prev, req_chan.temp_prev_two, req_chan.trial_step,
       req_chan.previous_step, req_chan.final_element, req_chan.empty_vector} <= c;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      req_chan.valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_gap();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(0, 16)) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (700) @(negedge clock);
   endtask

   function automatic step_cmd_type rand_cmd(input bit wellformed);
      step_cmd_type c;
      c = '0;
      c.cmd = wellformed ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
      c.time_now = wellformed ? {24'd0, 8'($urandom_range(0, 255)), $urandom()} : edge64();
      c.run_length = ($urandom_range(0, 3) == 0) ? edge64() : c.time_now + (rand64() >> 8);
      c.history_count = 8'($urandom());
      c.temp_trial = wellformed ? {{16{$urandom_range(0, 1) == 1}}, 16'($urandom()),
                                   $urandom()} : edge64();
      c.temp_prev = wellformed ? c.temp_trial + {{32{1'b0}}, 8'($urandom()), 24'd0}
                               : edge64();
      c.temp_prev_two = wellformed ? c.temp_prev - 64'($urandom_range(0, 1 << 24))
                                   : edge64();
      c.trial_step = wellformed ? {16'd0, 16'($urandom_range(0, 65535)), $urandom()}
                                : edge64();
      c.previous_step = ($urandom_range(0, 7) == 0) ? 64'd0 : edge64();
      c.final_element = ($urandom_range(0, 2) == 0);
      c.empty_vector = ($urandom_range(0, 11) == 0);
      return c;
   endfunction

   initial begin
      step_cmd_type c;
      req_chan.valid = 0;
      req_chan.cmd = 0; req_chan.time_now = 0; req_chan.run_length = 0;
      req_chan.history_count = 0; req_chan.temp_trial = 0; req_chan.temp_prev = 0;
      req_chan.temp_prev_two = 0; req_chan.trial_step = 0; req_chan.previous_step = 0;
      req_chan.final_element = 0; req_chan.empty_vector = 0;
      csr_chan.valid = 0; csr_chan.index = 0; csr_chan.data = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed
      c = '0; c.cmd = CmdSelect; c.run_length = AllOnes; c.history_count = 8'd255;
      send_cmd(c);
      c.time_now = AllOnes; send_cmd(c);
      c = '0; c.cmd = CmdElement; c.empty_vector = 1; send_cmd(c);
      c = '0; c.cmd = CmdElement; c.final_element = 1; c.history_count = 8'd2; send_cmd(c);
      c.temp_trial = AllOnes; c.temp_prev = 64'h7FFF_FFFF_FFFF_FFFF;
      c.temp_prev_two = 64'h8000_0000_0000_0000; c.trial_step = AllOnes;
      c.previous_step = 1; c.final_element = 0; send_cmd(c);
      c.previous_step = 0; c.final_element = 1; send_cmd(c);
      c = '0; c.cmd = CmdBoundary; c.time_now = AllOnes; send_cmd(c);
      c = '0; c.cmd = 2'd3; send_cmd(c);
      drain();
      write_reg(RegOutputInterval, OneQ32);
      write_reg(RegMinStep, AllOnes);
      write_reg(RegMaxStep, 64'd5);
      write_reg(RegHighestOrder, 64'd0);
      c = '0; c.cmd = CmdSelect; c.run_length = AllOnes; c.history_count = 8'd3; send_cmd(c);
      c = '0; c.cmd = CmdBoundary; c.time_now = OneQ32; send_cmd(c);
      c.time_now = 64'd12345; send_cmd(c);
      drain();
      write_reg(RegOutputInterval, AllOnes);
      write_reg(RegHighestOrder, 64'd3);
      write_reg(RegMinStep, 64'd0);
      write_reg(RegSafetyFactor, 64'h0000_0000_FFFF_FFFF);
      write_reg(RegErrorTolerance, 64'd0);
      write_reg(RegInitialStep, AllOnes);
      c = '0; c.cmd = CmdSelect; c.run_length = AllOnes; c.history_count = 8'd9; send_cmd(c);
      c = '0; c.cmd = CmdBoundary; c.time_now = AllOnes; send_cmd(c);
      send_cmd(c);
      c = '0; c.cmd = CmdElement; c.final_element = 1; c.temp_trial = OneQ32;
      c.temp_prev = OneQ32; send_cmd(c);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(RegInitialStep, (phase == 5) ? 64'd0 : {28'd0, 4'($urandom()), $urandom()});
         write_reg(RegMinStep, (phase == 1) ? 64'd0 : {40'd0, 24'($urandom())});
         write_reg(RegMaxStep, (phase == 2) ? AllOnes : {24'd0, 8'($urandom()), $urandom()});
         write_reg(RegOutputInterval, (phase == 0) ? 64'd0 : {28'd0, 4'($urandom()),
                                                             $urandom()});
         write_reg(RegSafetyFactor, (phase == 3) ? 64'd0 : 64'($urandom_range(40000, 90000)));
         write_reg(RegErrorTolerance, (phase == 4) ? AllOnes : {32'd0, $urandom()});
         write_reg(RegHighestOrder, 64'($urandom_range(0, 3)));
         for (int n = 0; n < 240; n++) begin
            c = rand_cmd($urandom_range(0, 4) != 0);
            if (phase == 2 && n == 60) begin
               fork
                  begin
                     hold_off = 1;
                     repeat (3000) @(negedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            if (n == 120) while (pending_count != 0) @(negedge clock);
            send_cmd(c);
            send_gap();
         end
         drain();
      end
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

[filelist.f]
rtl/abdf_pkg.sv
rtl/abdf_ifs.sv
rtl/abdf_arith.sv
rtl/adaptive_bdf_step_controller.sv
bench/abdf_pred_pkg.sv
bench/abdf_tb_ifs.sv
bench/abdf_step_checker.sv
bench/adaptive_bdf_step_controller_tb.sv
